[src/sstt_pkg.sv]
`default_nettype none

package sstt_pkg;

   localparam int TIMER_W = 32;
   localparam int AUTH_W  = 8;
   localparam int FUNC_W  = 3;
   localparam int CHAN_W  = 4;

   localparam logic [FUNC_W-1:0] FUNC_CONNECT      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DISCONNECT   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LINK_TICK    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SESSION_TICK = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY        = 3'd4;

   localparam logic [AUTH_W-1:0] AUTH_SYMMETRIC = 8'd2;

   localparam int SIDE_MASTER   = 0;
   localparam int SIDE_TERMINAL = 1;
   localparam int NUM_SIDES     = 2;

   // valid flag bits; the side bits line up with the side index
   localparam int VF_MASTER   = 0;
   localparam int VF_TERMINAL = 1;
   localparam int VF_TRM_SEC  = 2;
   localparam int VF_ANY      = 3;
   localparam int VF_W        = 4;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic               side;
      logic [CHAN_W-1:0]  channel;
      logic [TIMER_W-1:0] link_timeout;
      logic [AUTH_W-1:0]  auth_code;
      logic [TIMER_W-1:0] session_time;
      logic               module_powered;
      logic               prog_enabled;
      logic               secure_override;
   } cmd_type;

   typedef struct packed {
      logic connected;
      logic master_valid;
      logic terminal_valid;
      logic terminal_secure_valid;
      logic any_valid;
      logic stop_module;
   } result_type;

endpackage

`default_nettype wire

[src/sstt_core.sv]
`default_nettype none

module sstt_core
   import sstt_pkg::*;
#(
   parameter int NUM_PORTS = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire cmd_type    cmd,
   output      result_type result
);

   logic [TIMER_W-1:0] link_ff    [NUM_SIDES][NUM_PORTS];
   logic [TIMER_W-1:0] link_in    [NUM_SIDES][NUM_PORTS];
   logic [TIMER_W-1:0] session_ff [NUM_SIDES];
   logic [TIMER_W-1:0] session_in [NUM_SIDES];
   logic [AUTH_W-1:0]  auth_ff    [NUM_SIDES];
   logic [AUTH_W-1:0]  auth_in    [NUM_SIDES];
   logic [VF_W-1:0]    flags_ff;
   logic [VF_W-1:0]    flags_in;

   logic               in_range;
   logic [TIMER_W-1:0] sel_link;
   logic               expire;
   logic               conn;
   logic               stop;

   assign in_range = {1'b0, cmd.channel} < (CHAN_W+1)'(NUM_PORTS);

   always_comb begin
      link_in    = link_ff;
      session_in = session_ff;
      auth_in    = auth_ff;
      flags_in   = flags_ff;
      sel_link   = '0;
      expire     = 1'b0;
      conn       = 1'b0;
      stop       = 1'b0;

      for (int p = 0; p < NUM_PORTS; p++) begin
         if (cmd.channel == CHAN_W'(p)) begin
            sel_link = link_ff[cmd.side][p];
         end
      end

      if (fire) begin
         unique case (cmd.func)
            FUNC_CONNECT: begin
               session_in[cmd.side] = cmd.session_time;
               flags_in[cmd.side]   = |cmd.session_time;
               for (int p = 0; p < NUM_PORTS; p++) begin
                  if (in_range && cmd.channel == CHAN_W'(p)) begin
                     link_in[cmd.side][p] = cmd.link_timeout;
                  end
               end
               auth_in[cmd.side] = cmd.auth_code;
               conn = 1'b1;
            end
            FUNC_DISCONNECT: begin
               for (int p = 0; p < NUM_PORTS; p++) begin
                  link_in[cmd.side][p] = '0;
               end
               auth_in[cmd.side] = '0;
            end
            FUNC_LINK_TICK: begin
               for (int sd = 0; sd < NUM_SIDES; sd++) begin
                  expire = 1'b0;
                  for (int p = 0; p < NUM_PORTS; p++) begin
                     if (link_ff[sd][p] != '0) begin
                        link_in[sd][p] = link_ff[sd][p] - TIMER_W'(1);
                        if (link_ff[sd][p] == TIMER_W'(1)) begin
                           expire = 1'b1;
                        end
                     end
                  end
                  if (expire && auth_ff[sd] == AUTH_SYMMETRIC) begin
                     session_in[sd] = '0;
                     flags_in[sd]   = 1'b0;
                     auth_in[sd]    = '0;
                  end
               end
            end
            FUNC_SESSION_TICK: begin
               for (int sd = 0; sd < NUM_SIDES; sd++) begin
                  if (session_ff[sd] != '0) begin
                     session_in[sd] = session_ff[sd] - TIMER_W'(1);
                     if (session_ff[sd] != TIMER_W'(1)) begin
                        flags_in[VF_ANY] = 1'b1;
                        flags_in[sd]     = 1'b1;
                        if (sd == SIDE_TERMINAL) begin
                           flags_in[VF_TRM_SEC] = 1'b0;
                        end
                     end else begin
                        for (int p = 0; p < NUM_PORTS; p++) begin
                           link_in[sd][p] = '0;
                        end
                        flags_in[sd] = 1'b0;
                        auth_in[sd]  = '0;
                     end
                  end
               end
               if (session_in[SIDE_MASTER] == '0 && session_in[SIDE_TERMINAL] == '0) begin
                  auth_in[SIDE_MASTER]   = '0;
                  auth_in[SIDE_TERMINAL] = '0;
                  flags_in               = '0;
                  stop = cmd.module_powered & ~cmd.prog_enabled;
               end
            end
            FUNC_QUERY: begin
               conn = cmd.secure_override |
                      (in_range & ((sel_link != '0) | (session_ff[cmd.side] != '0)));
            end
            default: begin
            end
         endcase
      end
   end

   assign result.connected             = conn;
   assign result.master_valid          = flags_in[VF_MASTER];
   assign result.terminal_valid        = flags_in[VF_TERMINAL];
   assign result.terminal_secure_valid = flags_in[VF_TRM_SEC];
   assign result.any_valid             = flags_in[VF_ANY];
   assign result.stop_module           = stop;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int sd = 0; sd < NUM_SIDES; sd++) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
               link_ff[sd][p] <= '0;
            end
            session_ff[sd] <= '0;
            auth_ff[sd]    <= '0;
         end
         flags_ff <= '0;
      end else begin
         link_ff    <= link_in;
         session_ff <= session_in;
         auth_ff    <= auth_in;
         flags_ff   <= flags_in;
      end
   end

endmodule

`default_nettype wire

[src/secure_session_timeout_tracker.sv]
// Session timeout tracker for the master and terminal sides of a secure link. Each
// transaction on the req_ channel (connect, disconnect, link tick, session tick or
// status query) gives exactly one transaction on the rsp_ channel, in order. A new
// transaction is taken every clock cycle while req_stall is low, and each passes through an
// input register and a result register. All link timers, both session timers and the
// auth codes sit in flip-flops and are updated in parallel by the logic between the
// two registers, so a tick costs the same as any other operation. Channel indexes at
// or above NUM_PORTS leave the link timers untouched on a connect and make a query
// fail unless the secure override is set.
`default_nettype none

module secure_session_timeout_tracker
   import sstt_pkg::*;
#(
   parameter int NUM_PORTS = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [FUNC_W-1:0]  req_func,
   input  wire logic               req_side,
   input  wire logic [CHAN_W-1:0]  req_channel,
   input  wire logic [TIMER_W-1:0] req_link_timeout,
   input  wire logic [AUTH_W-1:0]  req_auth_code,
   input  wire logic [TIMER_W-1:0] req_session_time,
   input  wire logic               req_module_powered,
   input  wire logic               req_prog_enabled,
   input  wire logic               req_secure_override,

   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic               rsp_connected,
   output      logic               rsp_master_valid,
   output      logic               rsp_terminal_valid,
   output      logic               rsp_terminal_secure_valid,
   output      logic               rsp_any_valid,
   output      logic               rsp_stop_module
);

   logic       s1_valid_ff;
   logic       s1_valid_in;
   cmd_type    s1_cmd_ff;
   logic       s1_advance;
   logic       req_accept;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type core_result;

   assign s1_advance  = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall   = s1_valid_ff & ~s1_advance;
   assign req_accept  = req_valid & ~req_stall;
   assign s1_valid_in = req_accept | (s1_valid_ff & ~s1_advance);
   assign rsp_valid_in = s1_advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff.func            <= req_func;
         s1_cmd_ff.side            <= req_side;
         s1_cmd_ff.channel         <= req_channel;
         s1_cmd_ff.link_timeout    <= req_link_timeout;
         s1_cmd_ff.auth_code       <= req_auth_code;
         s1_cmd_ff.session_time    <= req_session_time;
         s1_cmd_ff.module_powered  <= req_module_powered;
         s1_cmd_ff.prog_enabled    <= req_prog_enabled;
         s1_cmd_ff.secure_override <= req_secure_override;
      end
   end

   sstt_core #(
      .NUM_PORTS (NUM_PORTS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_advance),
      .cmd    (s1_cmd_ff),
      .result (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_connected             = rsp_ff.connected;
   assign rsp_master_valid          = rsp_ff.master_valid;
   assign rsp_terminal_valid        = rsp_ff.terminal_valid;
   assign rsp_terminal_secure_valid = rsp_ff.terminal_secure_valid;
   assign rsp_any_valid             = rsp_ff.any_valid;
   assign rsp_stop_module           = rsp_ff.stop_module;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while pipeline has room");

   a_connect_succeeds: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_cmd_ff.func == FUNC_CONNECT) |=> (rsp_valid && rsp_connected))
      else $error("connect transaction did not report success");

   a_stop_clears_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stop_module) |->
         (!rsp_any_valid && !rsp_master_valid && !rsp_terminal_valid))
      else $error("stop request with valid flags still set");

   a_trm_sec_never_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_terminal_secure_valid)
      else $error("terminal secure valid flag raised");

endmodule

`default_nettype wire
